/* sv/arl_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the ARP block.
package arl_pkg;

    // Field widths fixed by the ARP format.
    localparam int LEN_W   = 11;
    localparam int TYPE_W  = 16;
    localparam int MAC_W   = 48;
    localparam int IP_W    = 32;
    localparam int SLOT_W  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 48;

    // Header checks. The reply frame itself goes out as EtherType 0x0806,
    // which is added outside this block.
    localparam logic [LEN_W-1:0]  ARP_MIN_LEN    = 11'd28;
    localparam logic [TYPE_W-1:0] HTYPE_ETHERNET = 16'h0001;
    localparam logic [TYPE_W-1:0] PTYPE_IPV4     = 16'h0800;
    localparam logic [TYPE_W-1:0] OP_REQUEST     = 16'h0001;
    localparam logic [TYPE_W-1:0] OP_REPLY       = 16'h0002;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'b1;

    // Result action codes.
    typedef enum logic [1:0] {
        ACT_IGNORE  = 2'd0,
        ACT_REPLY   = 2'd1,
        ACT_LEARNED = 2'd2,
        ACT_FULL    = 2'd3
    } action_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    idx_clear;
        logic    idx_inc;
        logic    tbl_write;
        logic    res_load;
        action_t act;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pkt_ok;
        logic op_req;
        logic op_rep;
        logic tip_hit;
        logic slot_hit;
        logic idx_last;
        logic out_free;
    } sts_t;

endpackage

/* sv/arl_dpath.sv */
// Datapath: configuration, captured word, learning table, walk index and result register.
module arl_dpath #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [arl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [arl_pkg::LEN_W-1:0]      packet_length,
    input  logic [arl_pkg::TYPE_W-1:0]     hardware_type,
    input  logic [arl_pkg::TYPE_W-1:0]     protocol_type,
    input  logic [arl_pkg::TYPE_W-1:0]     operation,
    input  logic [arl_pkg::MAC_W-1:0]      sender_mac,
    input  logic [arl_pkg::IP_W-1:0]       sender_ip,
    input  logic [arl_pkg::IP_W-1:0]       target_ip,
    input  arl_pkg::cmd_t                  cmd,
    output arl_pkg::sts_t                  sts,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [1:0]                     action,
    output logic [arl_pkg::MAC_W-1:0]      reply_dest_mac,
    output logic [arl_pkg::IP_W-1:0]       reply_dest_ip,
    output logic [arl_pkg::SLOT_W-1:0]     learned_slot
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int EXT_W = (IDX_W > arl_pkg::SLOT_W) ? IDX_W : arl_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    // Configuration registers.
    logic [arl_pkg::IP_W-1:0]  own_ip_reg;
    logic [arl_pkg::MAC_W-1:0] own_mac_reg;

    // Captured input word.
    logic [arl_pkg::LEN_W-1:0]  len_reg;
    logic [arl_pkg::TYPE_W-1:0] htype_reg;
    logic [arl_pkg::TYPE_W-1:0] ptype_reg;
    logic [arl_pkg::TYPE_W-1:0] op_reg;
    logic [arl_pkg::MAC_W-1:0]  smac_reg;
    logic [arl_pkg::IP_W-1:0]   sip_reg;
    logic [arl_pkg::IP_W-1:0]   tip_reg;

    // Learning table; an entry that was never written reads as empty.
    logic [arl_pkg::IP_W-1:0]  ip_mem  [TABLE_ENTRIES];
    logic [arl_pkg::MAC_W-1:0] mac_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  vld_reg;
    logic [arl_pkg::IP_W-1:0]  rd_ip_reg;
    logic                      rd_vld_reg;
    logic [arl_pkg::IP_W-1:0]  rd_ip_eff;

    // Walk index.
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [EXT_W-1:0] idx_ext;

    // Result register.
    logic                      out_valid_reg;
    logic [1:0]                action_reg;
    logic [arl_pkg::MAC_W-1:0] dmac_reg;
    logic [arl_pkg::IP_W-1:0]  dip_reg;
    logic [arl_pkg::SLOT_W-1:0] slot_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == arl_pkg::CFG_OWN_IP)
            begin
                own_ip_reg <= cfg_data[arl_pkg::IP_W-1:0];
            end
            if (cfg_index == arl_pkg::CFG_OWN_MAC)
            begin
                own_mac_reg <= cfg_data[arl_pkg::MAC_W-1:0];
            end
        end
    end

    // Capture the accepted word.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            len_reg   <= packet_length;
            htype_reg <= hardware_type;
            ptype_reg <= protocol_type;
            op_reg    <= operation;
            smac_reg  <= sender_mac;
            sip_reg   <= sender_ip;
            tip_reg   <= target_ip;
        end
    end

    // Walk index counter.
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // Table storage: one write port and one registered read port at the walk index.
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write)
        begin
            ip_mem[idx_reg]  <= sip_reg;
            mac_mem[idx_reg] <= smac_reg;
        end
        rd_ip_reg <= ip_mem[idx_reg];
    end

    // Entry valid bits, cleared at once by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.tbl_write)
            begin
                vld_reg[idx_reg] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[idx_reg];
        end
    end

    assign rd_ip_eff = rd_vld_reg ? rd_ip_reg : '0;

    // Status for the controller.
    always_comb
    begin
        sts.pkt_ok   = (len_reg >= arl_pkg::ARP_MIN_LEN) &&
                       (htype_reg == arl_pkg::HTYPE_ETHERNET) &&
                       (ptype_reg == arl_pkg::PTYPE_IPV4);
        sts.op_req   = (op_reg == arl_pkg::OP_REQUEST);
        sts.op_rep   = (op_reg == arl_pkg::OP_REPLY);
        sts.tip_hit  = (tip_reg == own_ip_reg);
        sts.slot_hit = (rd_ip_eff == '0) || (rd_ip_eff == sip_reg);
        sts.idx_last = (idx_reg == IDX_LAST);
        sts.out_free = !out_valid_reg || !out_stall;
    end

    assign idx_ext = EXT_W'(idx_reg);

    // Result register; fields that do not apply to the action read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            action_reg <= cmd.act;
            dmac_reg   <= (cmd.act == arl_pkg::ACT_REPLY) ? smac_reg : '0;
            dip_reg    <= (cmd.act == arl_pkg::ACT_REPLY) ? sip_reg : '0;
            slot_reg   <= (cmd.act == arl_pkg::ACT_LEARNED) ?
                          idx_ext[arl_pkg::SLOT_W-1:0] : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign action         = action_reg;
    assign reply_dest_mac = dmac_reg;
    assign reply_dest_ip  = dip_reg;
    assign learned_slot   = slot_reg;

endmodule

/* sv/arl_ctrl.sv */
// Controller: sequences classification, the table walk and the result hand-off.
module arl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  arl_pkg::sts_t sts,
    output arl_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_READ,
        S_CMP,
        S_DONE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    arl_pkg::action_t act_reg;
    arl_pkg::action_t act_next;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        cmd.capture   = 1'b0;
        cmd.idx_clear = 1'b0;
        cmd.idx_inc   = 1'b0;
        cmd.tbl_write = 1'b0;
        cmd.res_load  = 1'b0;
        cmd.act       = act_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if (sts.pkt_ok && sts.op_req && sts.tip_hit)
                begin
                    act_next   = arl_pkg::ACT_REPLY;
                    state_next = S_DONE;
                end
                else if (sts.pkt_ok && sts.op_rep)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = S_READ;
                end
                else
                begin
                    act_next   = arl_pkg::ACT_IGNORE;
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                // Table read at the walk index lands in the read register.
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sts.slot_hit)
                begin
                    cmd.tbl_write = 1'b1;
                    act_next      = arl_pkg::ACT_LEARNED;
                    state_next    = S_DONE;
                end
                else if (sts.idx_last)
                begin
                    act_next   = arl_pkg::ACT_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered action code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= arl_pkg::ACT_IGNORE;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

/* sv/arp_responder_and_learner.sv */
// Top level of the ARP responder and learner: controller, datapath and checks.
//
// Input channel (in_valid/in_stall) carries one parsed ARP packet per word.
// Words shorter than 28 bytes, or not Ethernet/IPv4, give action 0. A request
// for own_ip gives action 1 with the requester's MAC and IP; a reply is learned
// into the first empty or matching table slot (action 2), or dropped when the
// table is full (action 3). Framing of the reply frame is done downstream.
// Output channel (out_valid/out_stall) carries exactly one result word per input.
// A drop or reply passes from acceptance through the classify and done states; a learn
// also walks k slots (1..TABLE_ENTRIES), each through the read and compare states
// for the registered table read and compare; the done state waits while the output is stalled.
// One word is in work at a time; in_stall is high from acceptance until its
// result is loaded into the output register, and the next word is not accepted
// before that load. A new word can be accepted while a finished result still
// waits there; when the receiver stalls, the next result waits in the controller
// until the output register frees.
// Configuration (cfg_we/cfg_index/cfg_data) writes own_ip (0) or own_mac (1);
// write only while idle. Reset clears both registers, empties the table at once
// through per-entry valid bits, and drops any word in work.
module arp_responder_and_learner #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [arl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [arl_pkg::LEN_W-1:0]      packet_length,
    input  logic [arl_pkg::TYPE_W-1:0]     hardware_type,
    input  logic [arl_pkg::TYPE_W-1:0]     protocol_type,
    input  logic [arl_pkg::TYPE_W-1:0]     operation,
    input  logic [arl_pkg::MAC_W-1:0]      sender_mac,
    input  logic [arl_pkg::IP_W-1:0]       sender_ip,
    input  logic [arl_pkg::IP_W-1:0]       target_ip,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     action,
    output logic [arl_pkg::MAC_W-1:0]      reply_dest_mac,
    output logic [arl_pkg::IP_W-1:0]       reply_dest_ip,
    output logic [arl_pkg::SLOT_W-1:0]     learned_slot
);

    arl_pkg::cmd_t cmd;
    arl_pkg::sts_t sts;

    // Sequencer.
    arl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Registers, table and result path.
    arl_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .packet_length  (packet_length),
        .hardware_type  (hardware_type),
        .protocol_type  (protocol_type),
        .operation      (operation),
        .sender_mac     (sender_mac),
        .sender_ip      (sender_ip),
        .target_ip      (target_ip),
        .cmd            (cmd),
        .sts            (sts),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .action         (action),
        .reply_dest_mac (reply_dest_mac),
        .reply_dest_ip  (reply_dest_ip),
        .learned_slot   (learned_slot)
    );

    // An accepted word keeps the input side closed on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted again while a word is in work");

    // Reply addresses are zero unless the action is a reply.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action != arl_pkg::ACT_REPLY)) |->
        ((reply_dest_mac == '0) && (reply_dest_ip == '0)))
        else $error("reply fields set on a non-reply result");

    // The learned slot is zero unless an entry was learned.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action != arl_pkg::ACT_LEARNED)) |-> (learned_slot == '0))
        else $error("learned slot set on a result that learned nothing");

    // A result is only loaded once the table write, if any, is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !cmd.tbl_write)
        else $error("result loaded in the same cycle as a table write");

endmodule
